FILE: rtl/core/pgd_pkg.sv
// Shared types and constants of the proximity gesture detector.
package pgd_pkg;

  localparam int unsigned RdgW  = 10;
  localparam int unsigned SmpW  = 16;
  localparam int unsigned TickW = 8;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam logic [RdgW-1:0]  FarLowRst   = 10'd64;
  localparam logic [RdgW-1:0]  FarHighRst  = 10'd128;
  localparam logic [RdgW-1:0]  NearLowRst  = 10'd256;
  localparam logic [RdgW-1:0]  NearHighRst = 10'd512;
  localparam logic [TickW-1:0] TimeoutRst  = 8'd100;
  localparam logic [TickW-1:0] TicksMax    = 8'd255;

  // Register index, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_FAR_LOW   = 3'd0,
    REG_FAR_HIGH  = 3'd1,
    REG_NEAR_LOW  = 3'd2,
    REG_NEAR_HIGH = 3'd3,
    REG_TIMEOUT   = 3'd4
  } reg_idx_t;

  // Light codes for both the latched command and the live indication.
  typedef enum logic [CmdW-1:0] {
    CMD_NONE = 2'd0,
    CMD_FAR  = 2'd1,
    CMD_NEAR = 2'd2
  } cmd_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_1NEAR = 7'b0000010,
    ST_1FAR  = 7'b0000100,
    ST_2NEAR = 7'b0001000,
    ST_2FAR  = 7'b0010000,
    ST_3NEAR = 7'b0100000,
    ST_3FAR  = 7'b1000000
  } gst_t;

  typedef struct packed {
    logic far_hit;
    logic near_hit;
  } band_t;

  typedef struct packed {
    logic [RdgW-1:0] far_low;
    logic [RdgW-1:0] far_high;
    logic [RdgW-1:0] near_low;
    logic [RdgW-1:0] near_high;
  } bands_cfg_t;

endpackage

FILE: rtl/core/pgd_in_if.sv
// Input channel: four ADC words and the host clear flag.
interface pgd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_a;
  logic [15:0] sample_b;
  logic [15:0] sample_c;
  logic [15:0] sample_d;
  logic        clear_request;

  modport source (output valid, sample_a, sample_b, sample_c, sample_d, clear_request,
                  input ready);
  modport sink   (input valid, sample_a, sample_b, sample_c, sample_d, clear_request,
                  output ready);
endinterface

FILE: rtl/core/pgd_out_if.sv
// Result channel: latched light command and live indication.
interface pgd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] light_command;
  logic [1:0] temp_light;

  modport source (output valid, light_command, temp_light, input ready);
  modport sink   (input valid, light_command, temp_light, output ready);
endinterface

FILE: rtl/core/pgd_band.sv
// Averages the four readings and tests the average against the bands.
module pgd_band (
  input  logic [15:0]         sample_a,
  input  logic [15:0]         sample_b,
  input  logic [15:0]         sample_c,
  input  logic [15:0]         sample_d,
  input  pgd_pkg::bands_cfg_t cfg,
  output pgd_pkg::band_t      band
);

  logic [11:0] sum;
  logic [9:0]  avg;

  assign sum = {2'b00, sample_a[15:6]} + {2'b00, sample_b[15:6]}
             + {2'b00, sample_c[15:6]} + {2'b00, sample_d[15:6]};
  assign avg = sum[11:2];

  always_comb begin
    band = '0;
    priority if (avg < cfg.far_low) begin
      band = '0;
    end else if (avg < cfg.far_high) begin
      band.far_hit = 1'b1;
    end else if (avg < cfg.near_low) begin
      band = '0;
    end else if (avg < cfg.near_high) begin
      band.near_hit = 1'b1;
    end else begin
      band = '0;
    end
  end

endmodule

FILE: rtl/core/proximity_gesture_detector.sv
// Top level of the proximity gesture detector: registers, state machine, output buffer.
//
//   channel   ports      direction  handshake          payload
//   input     in_ch      sink       valid/ready        sample_a..d, clear_request
//   result    out_ch     source     valid/ready        light_command, temp_light
//   config    cfg_p*     slave      psel/penable       5 registers at 4*i, 32-bit data
//
// Each word is captured in an input register, then the band test and state update
// write its result into a two-entry output buffer; one word per cycle unless the output buffer is full.
// The result becomes valid once it is written from the input register into the output buffer.
// The output buffer keeps the input side moving while one result waits.
// Reset is synchronous on rst_n and returns state and registers to their defaults.
module proximity_gesture_detector (
  input  logic        clk,
  input  logic        rst_n,
  pgd_in_if.sink      in_ch,
  pgd_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers
  logic [9:0] far_low_r, far_high_r, near_low_r, near_high_r;
  logic [7:0] timeout_r;
  logic       cfg_wr;
  pgd_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = pgd_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_low_r   <= pgd_pkg::FarLowRst;
      far_high_r  <= pgd_pkg::FarHighRst;
      near_low_r  <= pgd_pkg::NearLowRst;
      near_high_r <= pgd_pkg::NearHighRst;
      timeout_r   <= pgd_pkg::TimeoutRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pgd_pkg::REG_FAR_LOW:   far_low_r   <= cfg_pwdata[9:0];
        pgd_pkg::REG_FAR_HIGH:  far_high_r  <= cfg_pwdata[9:0];
        pgd_pkg::REG_NEAR_LOW:  near_low_r  <= cfg_pwdata[9:0];
        pgd_pkg::REG_NEAR_HIGH: near_high_r <= cfg_pwdata[9:0];
        pgd_pkg::REG_TIMEOUT:   timeout_r   <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pgd_pkg::REG_FAR_LOW:   cfg_prdata = {22'd0, far_low_r};
      pgd_pkg::REG_FAR_HIGH:  cfg_prdata = {22'd0, far_high_r};
      pgd_pkg::REG_NEAR_LOW:  cfg_prdata = {22'd0, near_low_r};
      pgd_pkg::REG_NEAR_HIGH: cfg_prdata = {22'd0, near_high_r};
      pgd_pkg::REG_TIMEOUT:   cfg_prdata = {24'd0, timeout_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // Input register
  logic        s1_valid_r;
  logic [15:0] s1_a_r, s1_b_r, s1_c_r, s1_d_r;
  logic        s1_clear_r;
  logic        s1_move;
  logic        in_take;
  logic        out_pop;
  logic        out_valid_r, skid_valid_r;
  logic [1:0]  out_cmd_r, out_tmp_r, skid_cmd_r, skid_tmp_r;

  assign out_pop = out_valid_r && out_ch.ready;
  assign s1_move = s1_valid_r && (!skid_valid_r || out_pop);
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign in_take = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_a_r     <= in_ch.sample_a;
      s1_b_r     <= in_ch.sample_b;
      s1_c_r     <= in_ch.sample_c;
      s1_d_r     <= in_ch.sample_d;
      s1_clear_r <= in_ch.clear_request;
    end
  end

  // Band test
  pgd_pkg::bands_cfg_t bands_cfg;
  pgd_pkg::band_t      band;

  assign bands_cfg = '{far_low: far_low_r, far_high: far_high_r,
                       near_low: near_low_r, near_high: near_high_r};

  pgd_band u_band (
    .sample_a (s1_a_r),
    .sample_b (s1_b_r),
    .sample_c (s1_c_r),
    .sample_d (s1_d_r),
    .cfg      (bands_cfg),
    .band     (band)
  );

  // Gesture state
  pgd_pkg::gst_t state_r, state_nxt;
  logic [7:0]    ticks_r, ticks_nxt;
  pgd_pkg::cmd_t cmd_r, cmd_nxt, tmp_r, tmp_nxt;
  logic          timed_out;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    tmp_nxt   = tmp_r;
    ticks_nxt = (ticks_r != pgd_pkg::TicksMax) ? ticks_r + 8'd1 : ticks_r;

    if (band.far_hit) begin
      ticks_nxt = '0;
      unique case (state_r)
        pgd_pkg::ST_IDLE:  state_nxt = pgd_pkg::ST_1FAR;
        pgd_pkg::ST_1NEAR: state_nxt = pgd_pkg::ST_2FAR;
        pgd_pkg::ST_2NEAR, pgd_pkg::ST_3NEAR: begin
          state_nxt = pgd_pkg::ST_3FAR;
          tmp_nxt   = pgd_pkg::CMD_FAR;
        end
        default: ;
      endcase
    end else if (band.near_hit) begin
      ticks_nxt = '0;
      unique case (state_r)
        pgd_pkg::ST_IDLE: state_nxt = pgd_pkg::ST_1NEAR;
        pgd_pkg::ST_1FAR: state_nxt = pgd_pkg::ST_2NEAR;
        pgd_pkg::ST_2FAR, pgd_pkg::ST_3FAR: begin
          state_nxt = pgd_pkg::ST_3NEAR;
          tmp_nxt   = pgd_pkg::CMD_NEAR;
        end
        default: ;
      endcase
    end

    timed_out = ticks_nxt > timeout_r;
    if (timed_out) begin
      tmp_nxt = pgd_pkg::CMD_NONE;
      if (state_nxt == pgd_pkg::ST_3FAR) begin
        cmd_nxt = pgd_pkg::CMD_FAR;
      end else if (state_nxt == pgd_pkg::ST_3NEAR) begin
        cmd_nxt = pgd_pkg::CMD_NEAR;
      end
      state_nxt = pgd_pkg::ST_IDLE;
      ticks_nxt = timeout_r;
    end

    // A host clear leaves the live indication and the idle count alone.
    if (s1_clear_r) begin
      cmd_nxt   = pgd_pkg::CMD_NONE;
      state_nxt = pgd_pkg::ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pgd_pkg::ST_IDLE;
      ticks_r <= '0;
      cmd_r   <= pgd_pkg::CMD_NONE;
      tmp_r   <= pgd_pkg::CMD_NONE;
    end else if (s1_move) begin
      state_r <= state_nxt;
      ticks_r <= ticks_nxt;
      cmd_r   <= cmd_nxt;
      tmp_r   <= tmp_nxt;
    end
  end

  // Output buffer: head word plus one skid word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_pop) begin
        out_valid_r  <= skid_valid_r || s1_move;
        skid_valid_r <= skid_valid_r && s1_move;
      end else if (!out_valid_r) begin
        out_valid_r  <= s1_move;
      end else if (s1_move) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_pop) begin
      if (skid_valid_r) begin
        out_cmd_r <= skid_cmd_r;
        out_tmp_r <= skid_tmp_r;
        if (s1_move) begin
          skid_cmd_r <= cmd_nxt;
          skid_tmp_r <= tmp_nxt;
        end
      end else if (s1_move) begin
        out_cmd_r <= cmd_nxt;
        out_tmp_r <= tmp_nxt;
      end
    end else if (!out_valid_r) begin
      if (s1_move) begin
        out_cmd_r <= cmd_nxt;
        out_tmp_r <= tmp_nxt;
      end
    end else if (s1_move) begin
      skid_cmd_r <= cmd_nxt;
      skid_tmp_r <= tmp_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.light_command = out_cmd_r;
  assign out_ch.temp_light    = out_tmp_r;

  // Checks
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without a head word");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("gesture state is not one-hot");

  a_clear_drops_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && s1_clear_r) |=> (cmd_r == pgd_pkg::CMD_NONE && state_r == pgd_pkg::ST_IDLE))
    else $error("clear request did not drop the command and state");

  a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_valid_r) |-> in_ch.ready)
    else $error("input stalled while the output buffer had room");

endmodule

FILE: tb/proximity_gesture_detector_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the proximity gesture detector driven by randomized sensor ticks.
module proximity_gesture_detector_tb;
  import pgd_pkg::*;

  typedef enum int {K_MISS, K_FAR, K_NEAR, K_ANY} tick_kind_t;

  typedef struct packed {
    logic [SmpW-1:0] sample_a;
    logic [SmpW-1:0] sample_b;
    logic [SmpW-1:0] sample_c;
    logic [SmpW-1:0] sample_d;
    logic            clear_request;
    logic            wait_drain;
  } tick_t;

  typedef struct packed {
    cmd_t light_command;
    cmd_t temp_light;
  } light_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  pgd_in_if  in_ch();
  pgd_out_if out_ch();

  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [AddrW-1:0] cfg_paddr;
  logic [DataW-1:0] cfg_pwdata;
  logic [DataW-1:0] cfg_prdata;
  logic             cfg_pready;

  proximity_gesture_detector dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Predictor copy of the registers and the gesture state.
  logic [RdgW-1:0]  band_far_lo     = FarLowRst;
  logic [RdgW-1:0]  band_far_hi     = FarHighRst;
  logic [RdgW-1:0]  band_near_lo    = NearLowRst;
  logic [RdgW-1:0]  band_near_hi    = NearHighRst;
  logic [TickW-1:0] gesture_timeout = TimeoutRst;
  gst_t             gest_st         = ST_IDLE;
  logic [TickW-1:0] quiet_ticks     = '0;
  cmd_t             cmd_q           = CMD_NONE;
  cmd_t             ind_q           = CMD_NONE;

  tick_t      pending_ticks[$];
  light_res_t expected_lights[$];
  tick_t      sent_tick;
  light_res_t predicted;
  light_res_t oldest_light;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int words_sent     = 0;
  int results_seen   = 0;
  int far_latches    = 0;
  int near_latches   = 0;
  int phases         = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic band_t classify(input logic [RdgW-1:0] avg);
    band_t b;
    b = '0;
    // The far test runs first, so overlapping bands resolve to far.
    if (avg >= band_far_lo) begin
      if (avg < band_far_hi) b.far_hit = 1'b1;
      else if (avg >= band_near_lo && avg < band_near_hi) b.near_hit = 1'b1;
    end
    return b;
  endfunction

  task automatic advance_gesture(input tick_t t, output light_res_t res);
    logic [RdgW+1:0] sum;
    band_t           b;
    sum = {2'b00, t.sample_a[15:6]} + {2'b00, t.sample_b[15:6]}
        + {2'b00, t.sample_c[15:6]} + {2'b00, t.sample_d[15:6]};
    b = classify(sum[RdgW+1:2]);
    if (quiet_ticks != TicksMax) quiet_ticks++;
    if (b.far_hit) begin
      quiet_ticks = '0;
      case (gest_st)
        ST_IDLE:            gest_st = ST_1FAR;
        ST_1NEAR:           gest_st = ST_2FAR;
        ST_2NEAR, ST_3NEAR: begin
          gest_st = ST_3FAR;
          ind_q   = CMD_FAR;
        end
        default: ;
      endcase
    end else if (b.near_hit) begin
      quiet_ticks = '0;
      case (gest_st)
        ST_IDLE:          gest_st = ST_1NEAR;
        ST_1FAR:          gest_st = ST_2NEAR;
        ST_2FAR, ST_3FAR: begin
          gest_st = ST_3NEAR;
          ind_q   = CMD_NEAR;
        end
        default: ;
      endcase
    end
    if (quiet_ticks > gesture_timeout) begin
      ind_q = CMD_NONE;
      if (gest_st == ST_3FAR) begin
        cmd_q = CMD_FAR;
        far_latches++;
      end else if (gest_st == ST_3NEAR) begin
        cmd_q = CMD_NEAR;
        near_latches++;
      end
      gest_st     = ST_IDLE;
      quiet_ticks = gesture_timeout;
    end
    if (t.clear_request) begin
      cmd_q   = CMD_NONE;
      gest_st = ST_IDLE;
    end
    res.light_command = cmd_q;
    res.temp_light    = ind_q;
  endtask

  // Four readings spread at random around the wanted average; low bits are don't-care.
  function automatic tick_t build_tick(input int avg, input logic clr);
    tick_t t;
    int    total;
    int    r0;
    int    r1;
    int    r2;
    int    r3;
    total = 4 * avg + $urandom_range(3, 0);
    // Four 10-bit readings cannot sum past 4092.
    if (total > 4092) total = 4092;
    r0 = $urandom_range((total > 1023) ? 1023 : total, (total > 3069) ? total - 3069 : 0);
    total -= r0;
    r1 = $urandom_range((total > 1023) ? 1023 : total, (total > 2046) ? total - 2046 : 0);
    total -= r1;
    r2 = $urandom_range((total > 1023) ? 1023 : total, (total > 1023) ? total - 1023 : 0);
    r3 = total - r2;
    t.sample_a      = {r0[9:0], 6'($urandom_range(63, 0))};
    t.sample_b      = {r1[9:0], 6'($urandom_range(63, 0))};
    t.sample_c      = {r2[9:0], 6'($urandom_range(63, 0))};
    t.sample_d      = {r3[9:0], 6'($urandom_range(63, 0))};
    t.clear_request = clr;
    t.wait_drain    = 1'b0;
    return t;
  endfunction

  function automatic int pick_avg(input tick_kind_t kind);
    int    lo;
    int    hi;
    int    v;
    int    i;
    band_t b;
    lo = 0;
    hi = 1023;
    if (kind == K_FAR && band_far_lo < band_far_hi) begin
      lo = band_far_lo;
      hi = band_far_hi - 1;
    end
    if (kind == K_NEAR && band_near_lo < band_near_hi) begin
      lo = band_near_lo;
      hi = band_near_hi - 1;
    end
    v = $urandom_range(hi, lo);
    for (i = 0; i < 32; i++) begin
      v = $urandom_range(hi, lo);
      b = classify(v[RdgW-1:0]);
      if (kind == K_ANY || (kind == K_FAR && b.far_hit) || (kind == K_NEAR && b.near_hit) ||
          (kind == K_MISS && b == '0))
        return v;
    end
    return v;
  endfunction

  task automatic push_kind(input tick_kind_t kind);
    pending_ticks.push_back(build_tick(pick_avg(kind), $urandom_range(24, 0) == 0));
  endtask

  task automatic push_quiet(input int n);
    repeat (n) push_kind(K_MISS);
  endtask

  // Alternating near/far gestures with short noise, mostly ended by a quiet run past the timeout.
  task automatic push_gestures(input int n_words);
    int         pushed;
    int         steps;
    int         reps;
    int         noise;
    tick_kind_t band;
    pushed = 0;
    while (pushed < n_words) begin
      if ($urandom_range(9, 0) == 0) begin
        noise = $urandom_range(5, 1);
        repeat (noise) push_kind(K_ANY);
        pushed += noise;
      end else begin
        band  = $urandom_range(1, 0) ? K_FAR : K_NEAR;
        steps = $urandom_range(5, 1);
        repeat (steps) begin
          reps  = $urandom_range(3, 1);
          noise = (gesture_timeout >= 2) ? $urandom_range(1, 0) : 0;
          repeat (reps) push_kind(band);
          push_quiet(noise);
          pushed += reps + noise;
          band = (band == K_FAR) ? K_NEAR : K_FAR;
        end
        noise = (gesture_timeout <= 20) ? gesture_timeout + 1 + $urandom_range(2, 0)
                                        : $urandom_range(4, 0);
        push_quiet(noise);
        pushed += noise;
      end
    end
  endtask

  // Each register write is followed by a read back of the same register.
  task automatic cfg_write(input reg_idx_t idx, input int field);
    logic [DataW-1:0] mask;
    logic [DataW-1:0] value;
    mask  = (idx == REG_TIMEOUT) ? 32'h0000_00FF : 32'h0000_03FF;
    value = ($urandom & ~mask) | (field & mask);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_FAR_LOW:   band_far_lo     = value[RdgW-1:0];
      REG_FAR_HIGH:  band_far_hi     = value[RdgW-1:0];
      REG_NEAR_LOW:  band_near_lo    = value[RdgW-1:0];
      REG_NEAR_HIGH: band_near_hi    = value[RdgW-1:0];
      REG_TIMEOUT:   gesture_timeout = value[TickW-1:0];
      default: ;
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== (value & mask))
      report_mismatch($sformatf("register %s read %0h, wrote %0h", idx.name(), cfg_prdata,
                                value & mask));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic settle();
    while (pending_ticks.size() != 0 || in_ch.valid || expected_lights.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic start_phase(input int gap_pct, input int stall_pct, input int fl, input int fh,
                             input int nl, input int nh, input int tmo);
    settle();
    cfg_write(REG_FAR_LOW, fl);
    cfg_write(REG_FAR_HIGH, fh);
    cfg_write(REG_NEAR_LOW, nl);
    cfg_write(REG_NEAR_HIGH, nh);
    cfg_write(REG_TIMEOUT, tmo);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    phases++;
  endtask

  // Driver: predicts each accepted word, then offers the next one from the pending queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        advance_gesture(sent_tick, predicted);
        expected_lights.push_back(predicted);
        words_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99, 0) >= send_gap_pct &&
            !(pending_ticks[0].wait_drain && expected_lights.size() != 0)) begin
          sent_tick = pending_ticks.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.sample_a      <= sent_tick.sample_a;
          in_ch.sample_b      <= sent_tick.sample_b;
          in_ch.sample_c      <= sent_tick.sample_c;
          in_ch.sample_d      <= sent_tick.sample_d;
          in_ch.clear_request <= sent_tick.clear_request;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_lights.size() == 0) begin
          report_mismatch($sformatf("result cmd=%0d light=%0d with nothing expected",
                                    out_ch.light_command, out_ch.temp_light));
        end else begin
          oldest_light = expected_lights.pop_front();
          if (out_ch.light_command !== oldest_light.light_command)
            report_mismatch($sformatf("result %0d: light_command %0d, expected %0d",
                                      results_seen, out_ch.light_command,
                                      oldest_light.light_command));
          if (out_ch.temp_light !== oldest_light.temp_light)
            report_mismatch($sformatf("result %0d: temp_light %0d, expected %0d",
                                      results_seen, out_ch.temp_light,
                                      oldest_light.temp_light));
        end
      end
      out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  initial begin
    int    fl;
    int    fh;
    int    nl;
    int    nh;
    tick_t dir_tick;
    int    dir_avg[24];
    bit    dir_clr[24];
    dir_avg = '{63, 64, 127, 128, 255, 256, 511, 512, 100, 300, 100, 1000,
                1000, 1000, 1000, 300, 100, 300, 1000, 1000, 1000, 400, 70, 260};
    dir_clr = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0, 1};
    in_ch.valid         = 1'b0;
    in_ch.sample_a      = '0;
    in_ch.sample_b      = '0;
    in_ch.sample_c      = '0;
    in_ch.sample_d      = '0;
    in_ch.clear_request = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: word extremes, every band edge, both step-three indications,
    // timeouts that latch far and near, and clears with and without a band hit.
    start_phase(0, 0, FarLowRst, FarHighRst, NearLowRst, NearHighRst, 2);
    dir_tick = '0;
    pending_ticks.push_back(dir_tick);
    dir_tick = '1;
    dir_tick.wait_drain = 1'b0;
    pending_ticks.push_back(dir_tick);
    foreach (dir_avg[i]) pending_ticks.push_back(build_tick(dir_avg[i], dir_clr[i]));

    start_phase(0, 0, FarLowRst, FarHighRst, NearLowRst, NearHighRst, 3);
    push_gestures(40);

    // A timeout of zero ends the gesture on every tick without a hit.
    start_phase(50, 0, 0, 512, 512, 1023, 0);
    push_gestures(40);

    // A timeout of 255 never expires; the long quiet run drives the counter into saturation.
    fl = $urandom_range(200, 0);
    fh = fl + $urandom_range(200, 1);
    nl = fh + $urandom_range(200, 0);
    nh = nl + $urandom_range(300, 1);
    start_phase(0, 50, fl, fh, nl, nh, 255);
    push_gestures(25);
    push_quiet(270);

    // Bands in any order, possibly overlapping; the sender also waits for a full drain once.
    start_phase(34, 34, $urandom_range(1023, 0), $urandom_range(1023, 0),
                $urandom_range(1023, 0), $urandom_range(1023, 0), $urandom_range(8, 1));
    push_gestures(20);
    dir_tick = build_tick(pick_avg(K_ANY), 1'b0);
    dir_tick.wait_drain = 1'b1;
    pending_ticks.push_back(dir_tick);
    push_gestures(20);

    start_phase(0, 0, 0, 1, 1, 1023, 254);
    push_gestures(25);
    push_quiet(258);

    start_phase(50, 0, FarLowRst, FarHighRst, NearLowRst, NearHighRst, 1);
    push_gestures(40);

    fl = $urandom_range(300, 0);
    fh = fl + $urandom_range(300, 1);
    nl = fh + $urandom_range(100, 0);
    nh = nl + $urandom_range(300, 1);
    start_phase(34, 34, fl, fh, nl, nh, $urandom_range(12, 1));
    push_gestures(40);

    settle();
    $display("Summary: %0d sensor words sent, %0d results checked over %0d register settings.",
             words_sent, results_seen, phases);
    $display("Gestures latched %0d far and %0d near commands; %0d mismatches.",
             far_latches, near_latches, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run stopped at the time limit with %0d results still expected.",
             expected_lights.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pgd_pkg.sv
rtl/core/pgd_in_if.sv
rtl/core/pgd_out_if.sv
rtl/core/pgd_band.sv
rtl/core/proximity_gesture_detector.sv
tb/proximity_gesture_detector_tb.sv
